FILE: hw/rtl/rpsa_pkg.sv
// Package for the register pool status allocator.
// Holds the action, status and result codes, payload structs and reset constants.
// No dependencies.
package rpsa_pkg;

  typedef enum logic [2:0] {
    ACT_ALLOCATE = 3'd0,
    ACT_RESERVE  = 3'd1,
    ACT_MARK     = 3'd2,
    ACT_SET      = 3'd3,
    ACT_RESTORE  = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    ST_UNUSED   = 2'd0,
    ST_RESERVED = 2'd1,
    ST_INUSE    = 2'd2,
    ST_BAD      = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    RC_OK      = 2'd0,
    RC_INVALID = 2'd1,
    RC_FULL    = 2'd2
  } result_e;

  typedef enum logic {
    CFG_ENTRY_COUNT = 1'b0,
    CFG_DEFAULT_MAP = 1'b1
  } cfg_idx_e;

  localparam logic [4:0]  EntryCountRst = 5'd16;
  localparam logic [31:0] DefaultMapRst = 32'hA500_0000;
  localparam int          MapEntries    = 16;

  typedef struct packed {
    logic [2:0] action;
    logic [3:0] entry_index;
    logic [1:0] new_status;
  } req_t;

  typedef struct packed {
    logic [1:0] result_code;
    logic [3:0] granted_entry;
    logic [4:0] unused_count;
    logic [4:0] reserved_count;
    logic [4:0] inuse_count;
  } rsp_t;

endpackage

FILE: hw/rtl/rpsa_intf.sv
// Valid/ready channel interfaces for the register pool status allocator.
// Depends on rpsa_pkg for the request and response payload structs.
interface rpsa_req_if;
  import rpsa_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface rpsa_rsp_if;
  import rpsa_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

FILE: hw/rtl/register_pool_status_allocator_unit.sv
// Register pool status allocator: top level.
// Depends on rpsa_pkg and the channel interfaces in rpsa_intf.sv.
//
// Usage:
//   req_i carries one action per transaction (allocate, reserve, mark in
//   use, set status, restore defaults); rsp_o returns one result per
//   transaction with the result code, the granted entry and the status
//   counts after the action. cfg_we_i/cfg_idx_i/cfg_wdata_i write the entry
//   count (index 0) and the default status map (index 1) while idle.
//   The status table and the middle stage register are updated when a
//   request is accepted; the counts are tallied from the table into the
//   response register when the middle stage moves on. Throughput is one
//   transaction per cycle while the receiver keeps taking responses.
//   Reset loads every entry with its default from the reset map (code 3
//   reads as unused, entries at 16 and above are unused); the block is
//   ready right after reset.
//   When the receiver stalls, one response waits in the output register
//   and one more in the middle stage; req_i.ready then drops until the
//   output register drains.
module register_pool_status_allocator_unit #(
  parameter int POOL_ENTRIES = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  rpsa_req_if.sink               req_i,
  rpsa_rsp_if.source             rsp_o,
  input  logic                   cfg_we_i,
  input  rpsa_pkg::cfg_idx_e     cfg_idx_i,
  input  logic [31:0]            cfg_wdata_i
);
  import rpsa_pkg::*;

  localparam int CntBits = $clog2(POOL_ENTRIES + 1);
  localparam int NW      = (CntBits > 5) ? CntBits : 5;
  localparam logic [NW-1:0] PoolN = NW'(POOL_ENTRIES);

  logic [4:0]  entry_count_q;
  logic [31:0] map_q;
  status_e     status_q [POOL_ENTRIES];
  status_e     status_d [POOL_ENTRIES];

  logic        mid_valid_q;
  logic [1:0]  mid_rc_q;
  logic [3:0]  mid_grant_q;
  logic        rsp_valid_q;
  rsp_t        rsp_q;

  logic        out_free;
  logic        accept;

  logic [NW-1:0] ecnt_ext;
  logic [NW-1:0] n_present;
  logic [POOL_ENTRIES-1:0] present;
  logic [POOL_ENTRIES-1:0] sel;
  status_e     dflt [POOL_ENTRIES];
  status_e     cur;
  logic        in_range;
  logic        taken;
  logic        blocked;
  logic [1:0]  rc;
  logic [3:0]  grant;
  logic [4:0]  cnt_unused;
  logic [4:0]  cnt_reserved;
  logic [4:0]  cnt_inuse;

  assign out_free    = !rsp_valid_q || rsp_o.ready;
  assign req_i.ready = !mid_valid_q || out_free;
  assign accept      = req_i.valid && req_i.ready;
  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.data  = rsp_q;

  assign ecnt_ext  = NW'(entry_count_q);
  assign n_present = (ecnt_ext > PoolN) ? PoolN : ecnt_ext;
  assign in_range  = ({{(NW-4){1'b0}}, req_i.data.entry_index} < n_present);

  always_comb begin
    for (int i = 0; i < POOL_ENTRIES; i++) begin
      present[i] = (NW'(i) < n_present);
      sel[i]     = (int'(req_i.data.entry_index) == i);
      if (i < MapEntries) begin
        dflt[i] = status_e'(map_q[(2*i)%32 +: 2]);
      end else begin
        dflt[i] = ST_UNUSED;
      end
    end
  end

  always_comb begin
    cur = ST_UNUSED;
    for (int i = 0; i < POOL_ENTRIES; i++) begin
      if (sel[i]) begin
        cur = status_q[i];
      end
    end
  end

  // next table state and result code for the request on the channel
  always_comb begin
    rc      = RC_OK;
    grant   = '0;
    taken   = 1'b0;
    blocked = 1'b0;
    for (int i = 0; i < POOL_ENTRIES; i++) begin
      status_d[i] = status_q[i];
    end
    case (req_i.data.action)
      ACT_ALLOCATE: begin
        for (int i = 0; i < POOL_ENTRIES; i++) begin
          if (present[i] && status_q[i] == ST_UNUSED && !taken) begin
            status_d[i] = ST_INUSE;
            grant       = 4'(i);
            taken       = 1'b1;
          end
        end
        rc = taken ? RC_OK : RC_FULL;
      end
      ACT_RESERVE, ACT_MARK: begin
        if (!in_range) begin
          rc = RC_INVALID;
        end else if (cur == ST_INUSE) begin
          rc = RC_FULL;
        end else begin
          for (int i = 0; i < POOL_ENTRIES; i++) begin
            if (sel[i]) begin
              status_d[i] = (req_i.data.action == ACT_RESERVE) ? ST_RESERVED : ST_INUSE;
            end
          end
        end
      end
      ACT_SET: begin
        if (!in_range || req_i.data.new_status == ST_BAD) begin
          rc = RC_INVALID;
        end else begin
          for (int i = 0; i < POOL_ENTRIES; i++) begin
            if (sel[i]) begin
              status_d[i] = status_e'(req_i.data.new_status);
            end
          end
        end
      end
      ACT_RESTORE: begin
        // stop at the first present entry with a bad default code
        for (int i = 0; i < POOL_ENTRIES; i++) begin
          if (present[i] && !blocked) begin
            if (dflt[i] == ST_BAD) begin
              blocked = 1'b1;
            end else begin
              status_d[i] = dflt[i];
            end
          end
        end
        rc = blocked ? RC_INVALID : RC_OK;
      end
      default: begin
        rc = RC_INVALID;
      end
    endcase
  end

  // tally of the table as it stands after the item in the middle stage
  always_comb begin
    cnt_unused   = '0;
    cnt_reserved = '0;
    cnt_inuse    = '0;
    for (int i = 0; i < POOL_ENTRIES; i++) begin
      cnt_unused   = cnt_unused   + {4'd0, status_q[i] == ST_UNUSED};
      cnt_reserved = cnt_reserved + {4'd0, status_q[i] == ST_RESERVED};
      cnt_inuse    = cnt_inuse    + {4'd0, status_q[i] == ST_INUSE};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count_q <= EntryCountRst;
      map_q         <= DefaultMapRst;
      for (int i = 0; i < POOL_ENTRIES; i++) begin
        if (i < MapEntries && DefaultMapRst[(2*i)%32 +: 2] != ST_BAD) begin
          status_q[i] <= status_e'(DefaultMapRst[(2*i)%32 +: 2]);
        end else begin
          status_q[i] <= ST_UNUSED;
        end
      end
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ENTRY_COUNT: entry_count_q <= cfg_wdata_i[4:0];
          CFG_DEFAULT_MAP: map_q         <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (accept) begin
        for (int i = 0; i < POOL_ENTRIES; i++) begin
          status_q[i] <= status_d[i];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_valid_q <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (req_i.ready) begin
        mid_valid_q <= req_i.valid;
      end
      if (out_free) begin
        rsp_valid_q <= mid_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mid_rc_q    <= rc;
      mid_grant_q <= grant;
    end
    if (out_free && mid_valid_q) begin
      rsp_q.result_code    <= mid_rc_q;
      rsp_q.granted_entry  <= mid_grant_q;
      rsp_q.unused_count   <= cnt_unused;
      rsp_q.reserved_count <= cnt_reserved;
      rsp_q.inuse_count    <= cnt_inuse;
    end
  end

endmodule

FILE: dv/rpsa_tb_pkg.sv
`timescale 1ns / 1ps
// Scoreboard for the register pool status allocator: predicts each response and checks it.
// Depends on rpsa_pkg for the codes and payload structs.
package rpsa_tb_pkg;
  import rpsa_pkg::*;

  class pool_scoreboard;
    status_e     pool [MapEntries];
    int unsigned tally [3];
    logic [4:0]  entry_count;
    logic [31:0] default_map;
    rsp_t        outcomes [$];
    int          errors;
    int          transactions;
    int          grants;
    int          fulls;
    int          invalids;

    function new();
      status_e d;
      entry_count = EntryCountRst;
      default_map = DefaultMapRst;
      foreach (tally[k]) tally[k] = 0;
      for (int i = 0; i < MapEntries; i++) begin
        d = default_of(i);
        if (d == ST_BAD) d = ST_UNUSED;
        pool[i] = d;
        bump(d, 1'b1);
      end
    endfunction

    function void configure(logic [4:0] count, logic [31:0] map);
      entry_count = count;
      default_map = map;
    endfunction

    function status_e default_of(int i);
      return status_e'(default_map[2*i +: 2]);
    endfunction

    function int present();
      return (entry_count > MapEntries) ? MapEntries : int'(entry_count);
    endfunction

    function int pending();
      return outcomes.size();
    endfunction

    function void bump(status_e s, bit up);
      if (s == ST_BAD) return;
      if (up) tally[int'(s)]++;
      else if (tally[int'(s)] != 0) tally[int'(s)]--;
    endfunction

    function void move_entry(int i, status_e s);
      bump(s, 1'b1);
      bump(pool[i], 1'b0);
      pool[i] = s;
    endfunction

    // Applies one action to the shadow pool and returns the response it should produce.
    function rsp_t apply_action(req_t r);
      rsp_t    p;
      int      n;
      status_e d;
      status_e tgt;
      n = present();
      p = '0;
      p.result_code = RC_OK;
      case (r.action)
        ACT_ALLOCATE: begin
          p.result_code = RC_FULL;
          for (int i = 0; i < n; i++) begin
            if (pool[i] == ST_UNUSED) begin
              move_entry(i, ST_INUSE);
              p.granted_entry = 4'(i);
              p.result_code = RC_OK;
              break;
            end
          end
        end
        ACT_RESERVE, ACT_MARK: begin
          tgt = (r.action == ACT_RESERVE) ? ST_RESERVED : ST_INUSE;
          if (r.entry_index >= n) p.result_code = RC_INVALID;
          else if (pool[r.entry_index] == ST_INUSE) p.result_code = RC_FULL;
          else move_entry(r.entry_index, tgt);
        end
        ACT_SET: begin
          if (r.entry_index >= n || r.new_status == ST_BAD) p.result_code = RC_INVALID;
          else move_entry(r.entry_index, status_e'(r.new_status));
        end
        ACT_RESTORE: begin
          // stops at the first present entry with a bad default code
          for (int i = 0; i < n; i++) begin
            d = default_of(i);
            if (d == ST_BAD) begin
              p.result_code = RC_INVALID;
              break;
            end
            move_entry(i, d);
          end
        end
        default: p.result_code = RC_INVALID;
      endcase
      p.unused_count   = 5'(tally[int'(ST_UNUSED)]);
      p.reserved_count = 5'(tally[int'(ST_RESERVED)]);
      p.inuse_count    = 5'(tally[int'(ST_INUSE)]);
      return p;
    endfunction

    function void note_request(req_t r);
      rsp_t p;
      p = apply_action(r);
      transactions++;
      if (r.action == ACT_ALLOCATE && p.result_code == RC_OK) grants++;
      if (p.result_code == RC_FULL) fulls++;
      if (p.result_code == RC_INVALID) invalids++;
      outcomes.push_back(p);
    endfunction

    task report(string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      errors++;
    endtask

    task compare(string field, int got, int want);
      if (got !== want) report($sformatf("%s got %0d want %0d", field, got, want));
    endtask

    task check_response(rsp_t got);
      rsp_t want;
      if (outcomes.size() == 0) begin
        report($sformatf("response %h with no transaction pending", got));
        return;
      end
      want = outcomes.pop_front();
      compare("result_code", got.result_code, want.result_code);
      compare("granted_entry", got.granted_entry, want.granted_entry);
      compare("unused_count", got.unused_count, want.unused_count);
      compare("reserved_count", got.reserved_count, want.reserved_count);
      compare("inuse_count", got.inuse_count, want.inuse_count);
    endtask
  endclass

endpackage

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// Top-level testbench for register_pool_status_allocator_unit: directed and random actions.
// Depends on rpsa_pkg, rpsa_intf.sv and the scoreboard in rpsa_tb_pkg.
module tb_top;
  import rpsa_pkg::*;
  import rpsa_tb_pkg::*;

  localparam int StallLimit    = 2000;
  localparam int DrainCycles   = 8;
  localparam int RandomPhases  = 12;
  localparam int ItemsPerPhase = 150;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  cfg_idx_e    cfg_idx_i;
  logic [31:0] cfg_wdata_i;
  bit          steady;
  int          stuck;
  int          settings;
  pool_scoreboard sb;

  rpsa_req_if req_if();
  rpsa_rsp_if rsp_if();

  register_pool_status_allocator_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_if),
    .rsp_o       (rsp_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) sb.check_response(rsp_if.data);
    rsp_if.ready <= steady || ($urandom_range(0, 99) >= 31);
  end

  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) stuck <= 0;
    else stuck <= stuck + 1;
    if (stuck == StallLimit) begin
      $display("Watchdog: no transaction for %0d cycles", StallLimit);
      $display("Verification failed");
      $finish;
    end
  end

  function automatic req_t mk(logic [2:0] act, logic [3:0] idx, logic [1:0] st);
    req_t r;
    r.action      = act;
    r.entry_index = idx;
    r.new_status  = st;
    return r;
  endfunction

  function automatic req_t rand_request(int n);
    req_t r;
    int   pick;
    pick = $urandom_range(0, 99);
    if (pick < 26) r.action = ACT_ALLOCATE;
    else if (pick < 42) r.action = ACT_RESERVE;
    else if (pick < 58) r.action = ACT_MARK;
    else if (pick < 84) r.action = ACT_SET;
    else if (pick < 93) r.action = ACT_RESTORE;
    else r.action = 3'($urandom_range(ACT_RESTORE + 1, 7));
    if (n > 0 && $urandom_range(0, 9) < 8) r.entry_index = 4'($urandom_range(0, n - 1));
    else r.entry_index = 4'($urandom_range(0, 15));
    r.new_status = 2'($urandom_range(0, 3));
    return r;
  endfunction

  task automatic send_req(req_t r);
    while (!steady && $urandom_range(0, 99) < 31) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= r;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    sb.note_request(r);
  endtask

  task automatic drain_pipe();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic set_config(logic [4:0] count, logic [31:0] map);
    drain_pipe();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_ENTRY_COUNT;
    cfg_wdata_i <= {27'd0, count};
    @(posedge clk_i);
    cfg_idx_i   <= CFG_DEFAULT_MAP;
    cfg_wdata_i <= map;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.configure(count, map);
    settings++;
  endtask

  initial begin
    logic [4:0]  count;
    logic [31:0] map;
    sb           = new();
    steady       = 1'b0;
    settings     = 1;
    rst_ni       = 1'b0;
    cfg_we_i     <= 1'b0;
    cfg_idx_i    <= CFG_ENTRY_COUNT;
    cfg_wdata_i  <= '0;
    req_if.valid <= 1'b0;
    req_if.data  <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset map has entries 12/13 reserved and 14/15 in use
    send_req(mk(ACT_RESTORE, 4'd0, ST_UNUSED));
    send_req(mk(ACT_ALLOCATE, 4'd0, ST_UNUSED));
    send_req(mk(ACT_RESERVE, 4'd15, ST_UNUSED));
    send_req(mk(ACT_MARK, 4'd14, ST_UNUSED));
    send_req(mk(ACT_RESERVE, 4'd12, ST_UNUSED));
    send_req(mk(ACT_SET, 4'd13, ST_BAD));
    send_req(mk(ACT_SET, 4'd15, ST_UNUSED));
    send_req(mk(ACT_ALLOCATE, 4'd15, ST_BAD));
    send_req(mk(ACT_MARK, 4'd1, ST_UNUSED));
    send_req(mk(ACT_RESERVE, 4'd2, ST_UNUSED));
    send_req(mk(ACT_SET, 4'd2, ST_RESERVED));
    for (int a = ACT_RESTORE + 1; a < 8; a++) send_req(mk(3'(a), 4'd15, ST_BAD));
    send_req(mk(ACT_RESTORE, 4'd0, ST_UNUSED));
    // two present entries, bad default beyond them
    set_config(5'd2, 32'hFFFF_FFF4);
    send_req(mk(ACT_ALLOCATE, 4'd0, ST_UNUSED));
    send_req(mk(ACT_ALLOCATE, 4'd0, ST_UNUSED));
    send_req(mk(ACT_ALLOCATE, 4'd0, ST_UNUSED));
    send_req(mk(ACT_RESERVE, 4'd2, ST_UNUSED));
    send_req(mk(ACT_SET, 4'd1, ST_RESERVED));
    // bad default now present: restore stops partway
    set_config(5'd3, 32'hFFFF_FFF4);
    send_req(mk(ACT_RESTORE, 4'd0, ST_UNUSED));
    send_req(mk(ACT_MARK, 4'd15, ST_UNUSED));

    for (int ph = 0; ph < RandomPhases; ph++) begin
      case (ph)
        0: begin count = 5'd16; map = $urandom; end
        1: begin count = 5'd0;  map = 32'h0000_0000; end
        2: begin count = 5'd31; map = 32'hFFFF_FFFF; end
        3: begin count = 5'd1;  map = 32'h5555_5555; end
        4: begin count = 5'd17; map = 32'hAAAA_AAAA; end
        default: begin
          count = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
                                              : 5'($urandom_range(1, 16));
          map = $urandom;
          if (ph % 2 == 0)
            for (int i = 0; i < MapEntries; i++) map[2*i +: 2] = 2'($urandom_range(0, 2));
        end
      endcase
      set_config(count, map);
      steady = (ph == 5);
      for (int k = 0; k < ItemsPerPhase; k++) begin
        if (k == ItemsPerPhase / 2) drain_pipe();
        send_req(rand_request(sb.present()));
      end
    end
    steady = 1'b0;

    drain_pipe();
    repeat (DrainCycles) @(posedge clk_i);
    $display("Summary: %0d transactions over %0d register settings", sb.transactions, settings);
    $display("  %0d grants, %0d full or in-use answers, %0d invalid answers",
             sb.grants, sb.fulls, sb.invalids);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: register_pool_status_allocator_unit.f
hw/rtl/rpsa_pkg.sv
hw/rtl/rpsa_intf.sv
hw/rtl/register_pool_status_allocator_unit.sv
dv/rpsa_tb_pkg.sv
dv/tb_top.sv
